// File: src/tmps_pkg.sv
// shared constants, types and stage records for the triangle path-sum block
// no dependencies; used by every other file of the block but tmps_ram
package tmps_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int VALUE_W     = 16;
    localparam int MAX_SUM_W   = 21;
    localparam int ROW_W       = $clog2(MAX_ROWS + 1);
    localparam int COL_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    // node sums stay within MAX_ROWS * 2^15 in magnitude
    localparam int SUM_W       = VALUE_W + 1 + $clog2(MAX_ROWS);
    localparam int SAT_W       = (SUM_W > MAX_SUM_W + 1) ? SUM_W : MAX_SUM_W + 1;
    localparam int MAX_SUM_TOP = (1 << MAX_SUM_W) - 1;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [SAT_W-1:0]   t_wide;
    typedef logic [ROW_W-1:0]          t_row;
    typedef logic [COL_W-1:0]          t_col;
    typedef logic [MAX_SUM_W-1:0]      t_max_sum;

    // position of the next item, from the sequencer
    typedef struct packed {
        t_row row;
        t_col col;
        logic skip;
    } t_pos;

    // item held in the compute stage
    typedef struct packed {
        t_value value;
        logic   last;
        t_row   row;
        t_col   col;
        logic   skip;
        logic   fwd;
    } t_stage;

    typedef struct packed {
        t_max_sum max_sum;
        logic     overflow;
    } t_result;

endpackage

// File: src/tmps_if.sv
// valid/ready channels of the triangle path-sum block: input items and results
// depends on tmps_pkg
interface tmps_in_if;
    logic             valid;
    logic             ready;
    tmps_pkg::t_value node_value;
    logic             last;

    modport source (output valid, output node_value, output last, input ready);
    modport sink (input valid, input node_value, input last, output ready);
endinterface

interface tmps_out_if;
    logic               valid;
    logic               ready;
    tmps_pkg::t_max_sum max_sum;
    logic               overflow;

    modport source (output valid, output max_sum, output overflow, input ready);
    modport sink (input valid, input max_sum, input overflow, output ready);
endinterface

// File: src/triangle_max_path_sum.sv
// Streams a number triangle in row-major order and reports the best root-started
// path sum (never below zero) and an overflow flag on the item marked last.
// Takes one item per clock, back to back: the row store is read when an item is
// accepted and the new node sum is written back as the item leaves the compute
// stage, with a bypass for the one case where an item reads the entry that the
// item ahead is writing. A result waits in an output register; input stalls only
// while a last item finds that register still full. Items past MAX_ROWS rows are
// dropped and raise overflow. The row store is not cleared at reset; no item ever
// uses an entry the current triangle has not written.
// depends on tmps_pkg, tmps_if, tmps_ram, tmps_seq, tmps_node
module triangle_max_path_sum (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmps_in_if.sink    i_item,
    tmps_out_if.source o_result
);

    tmps_pkg::t_pos    pos;
    tmps_pkg::t_stage  r_s1, n_s1;
    logic              r_s1_valid;
    tmps_pkg::t_sum    r_fwd_data;
    tmps_pkg::t_sum    rdata;
    tmps_pkg::t_sum    above_raw;
    tmps_pkg::t_sum    node;
    tmps_pkg::t_result res;
    tmps_pkg::t_result r_out;
    logic              r_out_valid;
    logic              s1_fire;
    logic              acc;
    logic              ram_we;

    assign s1_fire       = r_s1_valid && (!r_s1.last || !r_out_valid || o_result.ready);
    assign i_item.ready  = !r_s1_valid || s1_fire;
    assign acc           = i_item.valid && i_item.ready;
    assign ram_we        = s1_fire && !r_s1.skip;

    tmps_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_last  (i_item.last),
        .o_pos   (pos)
    );

    tmps_ram #(
        .WIDTH (tmps_pkg::SUM_W),
        .DEPTH (tmps_pkg::MAX_ROWS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1.col),
        .i_wdata (node),
        .i_re    (acc),
        .i_raddr (pos.col),
        .o_rdata (rdata)
    );

    // bypass the write that lands in the same cycle as this read
    assign above_raw = r_s1.fwd ? r_fwd_data : rdata;

    tmps_node u_node (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (s1_fire),
        .i_stage     (r_s1),
        .i_above_raw (above_raw),
        .o_node      (node),
        .o_result    (res)
    );

    always_comb begin
        n_s1.value = i_item.node_value;
        n_s1.last  = i_item.last;
        n_s1.row   = pos.row;
        n_s1.col   = pos.col;
        n_s1.skip  = pos.skip;
        n_s1.fwd   = ram_we && (r_s1.col == pos.col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire && r_s1.last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1       <= n_s1;
            r_fwd_data <= node;
        end
        if (s1_fire && r_s1.last) begin
            r_out <= res;
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.max_sum  = r_out.max_sum;
    assign o_result.overflow = r_out.overflow;

`ifndef SYNTHESIS
    a_fwd_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && ram_we && (r_s1.col == pos.col) |=> r_s1.fwd)
        else $error("same-entry read and write not bypassed");

    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1.last && r_out_valid && !o_result.ready |-> !i_item.ready)
        else $error("input taken while a result is blocked");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_result.ready |=> r_out_valid && $stable(r_out))
        else $error("pending result lost or changed");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pos.row <= tmps_pkg::ROW_W'(tmps_pkg::MAX_ROWS)
        && (pos.skip || tmps_pkg::ROW_W'(pos.col) <= pos.row))
        else $error("row or column counter out of range");
`endif

endmodule

// File: src/tmps_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module tmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/tmps_seq.sv
// row and column counters that place each accepted item in the triangle
// depends on tmps_pkg
module tmps_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_acc,
    input  logic           i_last,
    output tmps_pkg::t_pos o_pos
);

    tmps_pkg::t_row r_row, n_row;
    tmps_pkg::t_col r_col, n_col;
    logic           full;

    assign full = (r_row == tmps_pkg::ROW_W'(tmps_pkg::MAX_ROWS));

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_acc) begin
            if (i_last) begin
                n_row = '0;
                n_col = '0;
            end else if (!full) begin
                if (tmps_pkg::ROW_W'(r_col) >= r_row) begin
                    n_col = '0;
                    n_row = tmps_pkg::ROW_W'(r_row + 1'b1);
                end else begin
                    n_col = tmps_pkg::COL_W'(r_col + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    assign o_pos.row  = r_row;
    assign o_pos.col  = r_col;
    assign o_pos.skip = full;

endmodule

// File: src/tmps_node.sv
// node sum, best-parent choice, running maximum and overflow tracking
// depends on tmps_pkg
module tmps_node (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  tmps_pkg::t_stage  i_stage,
    input  tmps_pkg::t_sum    i_above_raw,
    output tmps_pkg::t_sum    o_node,
    output tmps_pkg::t_result o_result
);

    tmps_pkg::t_sum  r_left;
    tmps_pkg::t_sum  r_best;
    logic            r_ovf;
    tmps_pkg::t_sum  above;
    tmps_pkg::t_sum  parent;
    tmps_pkg::t_sum  node;
    tmps_pkg::t_sum  n_best;
    logic            n_ovf;
    tmps_pkg::t_wide wide;
    logic            has_above;

    assign has_above = tmps_pkg::ROW_W'(i_stage.col) < i_stage.row;
    assign above     = has_above ? i_above_raw : '0;

    always_comb begin
        if (i_stage.row == '0) begin
            parent = '0;
        end else if (i_stage.col == '0) begin
            parent = above;
        end else if (tmps_pkg::ROW_W'(i_stage.col) == i_stage.row) begin
            parent = r_left;
        end else begin
            parent = (above > r_left) ? above : r_left;
        end
    end

    assign node   = tmps_pkg::t_sum'(i_stage.value) + parent;
    assign n_best = (!i_stage.skip && node > r_best) ? node : r_best;
    assign n_ovf  = r_ovf | i_stage.skip;
    assign wide   = tmps_pkg::t_wide'(n_best);

    always_comb begin
        o_result.overflow = n_ovf;
        if (wide > tmps_pkg::t_wide'(tmps_pkg::MAX_SUM_TOP)) begin
            o_result.max_sum = tmps_pkg::MAX_SUM_W'(tmps_pkg::MAX_SUM_TOP);
        end else if (wide < 0) begin
            o_result.max_sum = '0;
        end else begin
            o_result.max_sum = wide[tmps_pkg::MAX_SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_best <= '0;
            r_ovf  <= 1'b0;
        end else if (i_fire) begin
            if (i_stage.last) begin
                r_left <= '0;
                r_best <= '0;
                r_ovf  <= 1'b0;
            end else begin
                // left parent is the previous row's entry before it is overwritten
                if (!i_stage.skip) begin
                    r_left <= above;
                end
                r_best <= n_best;
                r_ovf  <= n_ovf;
            end
        end
    end

    assign o_node = node;

endmodule
